// ----- hdl/izh_pkg.sv -----
package izh_pkg;

   // sizes of the channel fields
   localparam int NEURONS_DEF = 1024;
   localparam int NEURON_W    = 10;
   localparam int SYN_W       = 48;
   localparam int DATA_W      = 32;
   localparam int STEPS_W     = 7;
   localparam int GAIN_W      = 24;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 24;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_STEPS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN  = 1'd1;

   // q16.16 constants
   localparam logic signed [31:0] V_PEAK  = 32'sd1966080;
   localparam logic signed [31:0] V_FLOOR = -32'sd6553600;
   localparam logic signed [31:0] C_140   = 32'sd9175040;
   // 0.04 in q0.24
   localparam logic [19:0]        K_004   = 20'd671089;

   // datapath widths
   localparam int DV_W          = 50;
   localparam int MAG_W         = 52;
   localparam int DIV_STEP_BITS = 4;

   // kind of work for a word
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_RESET = 2'd1;
   localparam logic [1:0] KIND_STEP  = 2'd2;

   typedef struct packed {
      logic [NEURON_W-1:0]      neuron;
      logic [1:0]               kind;
      logic signed [DATA_W-1:0] v;
      logic signed [DATA_W-1:0] u;
      logic signed [DATA_W-1:0] rv;
      logic signed [DATA_W-1:0] ru;
   } side_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (x < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

// ----- hdl/izh_if.sv -----
interface izh_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  op;
   logic [izh_pkg::NEURON_W-1:0]          neuron;
   logic signed [izh_pkg::SYN_W-1:0]      syn_current;
   logic signed [izh_pkg::DATA_W-1:0]     ext_current;
   logic signed [izh_pkg::DATA_W-1:0]     noise_sample;
   logic signed [izh_pkg::DATA_W-1:0]     param_a;
   logic signed [izh_pkg::DATA_W-1:0]     param_b;
   logic signed [izh_pkg::DATA_W-1:0]     param_c;
   logic signed [izh_pkg::DATA_W-1:0]     param_d;
   logic signed [izh_pkg::DATA_W-1:0]     load_v;
   logic signed [izh_pkg::DATA_W-1:0]     load_u;
   modport source (output valid, op, neuron, syn_current, ext_current, noise_sample,
                   param_a, param_b, param_c, param_d, load_v, load_u, input ready);
   modport sink (input valid, op, neuron, syn_current, ext_current, noise_sample,
                 param_a, param_b, param_c, param_d, load_v, load_u, output ready);
endinterface

interface izh_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [izh_pkg::NEURON_W-1:0]      neuron_out;
   logic signed [izh_pkg::DATA_W-1:0] v_out;
   logic signed [izh_pkg::DATA_W-1:0] u_out;
   logic                              spiked;
   modport source (output valid, neuron_out, v_out, u_out, spiked, input ready);
   modport sink (input valid, neuron_out, v_out, u_out, spiked, output ready);
endinterface

interface izh_csr_if;
   logic                               valid;
   logic                               ready;
   logic [izh_pkg::CSR_IDX_W-1:0]      index;
   logic [izh_pkg::CSR_DATA_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/izh_ram.sv -----
module izh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/izh_div.sv -----
// pipelined signed / unsigned divide, truncating toward zero
module izh_div #(
   parameter int IN_W      = 50,
   parameter int MAG_W     = 52,
   parameter int STEP_BITS = 4,
   parameter int DIV_W     = 7,
   localparam int STAGES   = MAG_W / STEP_BITS
) (
   input  logic                   clock,
   input  logic [STAGES:0]        en,
   input  logic signed [IN_W-1:0] dividend,
   input  logic [DIV_W-1:0]       divisor,
   output logic                   q_neg,
   output logic [MAG_W-1:0]       q_mag
);

   logic             neg_ff [0:STAGES];
   logic [MAG_W-1:0] num_ff [0:STAGES];
   logic [DIV_W-1:0] rem_ff [0:STAGES];
   logic [MAG_W-1:0] num_in [1:STAGES];
   logic [DIV_W-1:0] rem_in [1:STAGES];
   logic signed [MAG_W-1:0] ext;

   assign ext = MAG_W'(dividend);

   // sign and magnitude stage
   always_ff @(posedge clock) begin
      if (en[0]) begin
         neg_ff[0] <= dividend[IN_W-1];
         num_ff[0] <= dividend[IN_W-1] ? MAG_W'(-ext) : MAG_W'(ext);
         rem_ff[0] <= '0;
      end
   end

   for (genvar s = 1; s <= STAGES; s++) begin : g_stage
      always_comb begin
         logic [DIV_W:0]   t;
         logic [MAG_W-1:0] n;
         logic [DIV_W-1:0] r;
         n = num_ff[s-1];
         r = rem_ff[s-1];
         for (int b = 0; b < STEP_BITS; b++) begin
            t = {r, n[MAG_W-1]};
            n = {n[MAG_W-2:0], 1'b0};
            if (t >= {1'b0, divisor}) begin
               t    = t - {1'b0, divisor};
               n[0] = 1'b1;
            end
            r = t[DIV_W-1:0];
         end
         num_in[s] = n;
         rem_in[s] = r;
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            neg_ff[s] <= neg_ff[s-1];
            num_ff[s] <= num_in[s];
            rem_ff[s] <= rem_in[s];
         end
      end
   end

   assign q_neg = neg_ff[STAGES];
   assign q_mag = num_ff[STAGES];

endmodule

// ----- hdl/izhikevich_neuron_step_core.sv -----
// izhikevich neuron update engine. v and u of every neuron sit in two single-port-write
// synchronous rams; a load word writes both, a step word reads them, runs one euler step
// of the q16.16 model (quadratic term, recovery, synaptic, external and noise currents,
// divided by steps_per_ms) and writes the new values back as its result leaves. the
// datapath is a pipeline: ram read, four multiply/add stages, a 14-stage radix-16
// divider lane for each of dv and du, then clamp and write-back into the result register.
// one word is taken per cycle while its neuron is not in flight and the consumer keeps
// taking results. a word whose neuron is still somewhere in the pipeline is held off
// until that earlier word has written back. configuration is accepted every cycle and
// should only be written while the engine is empty.
module izhikevich_neuron_step_core #(
   parameter int NEURONS = izh_pkg::NEURONS_DEF
) (
   input logic     clock,
   input logic     reset,
   izh_req_if.sink   req_ch,
   izh_rsp_if.source rsp_ch,
   izh_csr_if.sink   csr_ch
);

   localparam int AW      = (NEURONS > 1) ? $clog2(NEURONS) : 1;
   localparam int DSTAGES = izh_pkg::MAG_W / izh_pkg::DIV_STEP_BITS;
   localparam int DL      = DSTAGES + 1;   // divider stage count incl. sign stage
   localparam int DFIRST  = 5;             // first divider stage
   localparam int LAST    = DFIRST + DL - 1;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [izh_pkg::STEPS_W-1:0] steps_ff;
   logic [izh_pkg::GAIN_W-1:0]  gain_ff;
   logic [izh_pkg::STEPS_W-1:0] eff_div;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= izh_pkg::STEPS_W'(1);
         gain_ff  <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            izh_pkg::REG_STEPS: steps_ff <= csr_ch.data[izh_pkg::STEPS_W-1:0];
            izh_pkg::REG_GAIN:  gain_ff  <= csr_ch.data[izh_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // zero steps behaves as one
   assign eff_div = (steps_ff == '0) ? izh_pkg::STEPS_W'(1) : steps_ff;

   // ------------------------------------------------------------------
   // pipeline flow: each stage moves when empty or when its successor moves
   // ------------------------------------------------------------------
   logic            vld_ff [0:LAST];
   logic [AW-1:0]   idx_ff [0:LAST];
   logic [LAST:0]   adv;
   logic            out_vld_ff;
   logic            adv_out;
   logic            hazard;
   logic            accept;
   logic [AW-1:0]   req_idx;
   logic [26:0]     red;

   assign adv_out = !out_vld_ff || rsp_ch.ready;

   always_comb begin
      adv[LAST] = !vld_ff[LAST] || adv_out;
      for (int k = LAST - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   // neuron index folded into the memory depth
   always_comb begin
      red = 27'(req_ch.neuron);
      for (int k = izh_pkg::NEURON_W - 1; k >= 0; k--) begin
         if (red >= (27'(NEURONS) << k)) begin
            red = red - (27'(NEURONS) << k);
         end
      end
      req_idx = red[AW-1:0];
   end

   // hold off a word whose neuron is still in flight
   always_comb begin
      hazard = 1'b0;
      for (int k = 0; k <= LAST; k++) begin
         if (vld_ff[k] && idx_ff[k] == req_idx) begin
            hazard = 1'b1;
         end
      end
   end

   assign req_ch.ready = adv[0] && !hazard;
   assign accept       = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LAST; k++) begin
            vld_ff[k] <= 1'b0;
         end
         out_vld_ff <= 1'b0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= accept;
         end
         for (int k = 1; k <= LAST; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
         if (adv_out) begin
            out_vld_ff <= vld_ff[LAST];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         idx_ff[0] <= req_idx;
      end
      for (int k = 1; k <= LAST; k++) begin
         if (adv[k]) begin
            idx_ff[k] <= idx_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // state memories
   // ------------------------------------------------------------------
   logic                              ram_we;
   logic signed [izh_pkg::DATA_W-1:0] wr_v, wr_u;
   logic [izh_pkg::DATA_W-1:0]        rd_v, rd_u;

   assign ram_we = vld_ff[LAST] && adv_out;

   izh_ram #(.WIDTH(izh_pkg::DATA_W), .DEPTH(NEURONS)) u_membrane_mem (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff[LAST]),
      .wr_data (wr_v),
      .rd_en   (accept),
      .rd_addr (req_idx),
      .rd_data (rd_v)
   );

   izh_ram #(.WIDTH(izh_pkg::DATA_W), .DEPTH(NEURONS)) u_recovery_mem (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff[LAST]),
      .wr_data (wr_u),
      .rd_en   (accept),
      .rd_addr (req_idx),
      .rd_data (rd_u)
   );

   // ------------------------------------------------------------------
   // stage 0: word fields alongside the ram read
   // ------------------------------------------------------------------
   logic                               op0_ff;
   logic [izh_pkg::NEURON_W-1:0]       nrn0_ff;
   logic signed [izh_pkg::SYN_W-1:0]   syn0_ff;
   logic signed [izh_pkg::DATA_W-1:0]  ext0_ff, noise0_ff, a0_ff, b0_ff, c0_ff, d0_ff;
   logic signed [izh_pkg::DATA_W-1:0]  lv0_ff, lu0_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         op0_ff    <= req_ch.op;
         nrn0_ff   <= req_ch.neuron;
         syn0_ff   <= req_ch.syn_current;
         ext0_ff   <= req_ch.ext_current;
         noise0_ff <= req_ch.noise_sample;
         a0_ff     <= req_ch.param_a;
         b0_ff     <= req_ch.param_b;
         c0_ff     <= req_ch.param_c;
         d0_ff     <= req_ch.param_d;
         lv0_ff    <= req_ch.load_v;
         lu0_ff    <= req_ch.load_u;
      end
   end

   // ------------------------------------------------------------------
   // stage 1: v squared, b*v, gain*noise; decide load / reset / step
   // ------------------------------------------------------------------
   logic signed [izh_pkg::DATA_W-1:0] v0, u0;
   logic [31:0]                       vmag;
   logic [63:0]                       sq_in, sq_ff;
   logic signed [63:0]                bv_in, bv_ff;
   logic signed [56:0]                gn_in, gn_ff;
   izh_pkg::side_type                 side_in;
   izh_pkg::side_type                 side_ff [1:LAST];
   logic signed [izh_pkg::DATA_W-1:0] a1_ff, ext1_ff;
   logic signed [izh_pkg::SYN_W-1:0]  syn1_ff;

   assign v0 = rd_v;
   assign u0 = rd_u;

   always_comb begin
      vmag  = v0[31] ? (~rd_v + 32'd1) : rd_v;
      sq_in = 64'(vmag) * 64'(vmag);
      bv_in = 64'(b0_ff) * 64'(v0);
      gn_in = 57'($signed({1'b0, gain_ff})) * 57'(noise0_ff);

      side_in.neuron = nrn0_ff;
      side_in.v      = v0;
      side_in.u      = u0;
      if (!op0_ff) begin
         side_in.kind = izh_pkg::KIND_LOAD;
         side_in.rv   = lv0_ff;
         side_in.ru   = lu0_ff;
      end else if (v0 == izh_pkg::V_PEAK) begin
         // spike reset: v to c, u grows by d
         side_in.kind = izh_pkg::KIND_RESET;
         side_in.rv   = c0_ff;
         side_in.ru   = izh_pkg::sat32(64'(u0) + 64'(d0_ff));
      end else begin
         side_in.kind = izh_pkg::KIND_STEP;
         side_in.rv   = lv0_ff;
         side_in.ru   = lu0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         sq_ff      <= sq_in;
         bv_ff      <= bv_in;
         gn_ff      <= gn_in;
         a1_ff      <= a0_ff;
         ext1_ff    <= ext0_ff;
         syn1_ff    <= syn0_ff;
         side_ff[1] <= side_in;
      end
      for (int k = 2; k <= LAST; k++) begin
         if (adv[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 2: 0.04 v^2 partial products, saturated b*v - u, linear terms
   // ------------------------------------------------------------------
   logic [59:0]                       qh_in, qh_ff;
   logic [19:0]                       ql_in, ql_ff;
   logic [43:0]                       ql_full;
   logic signed [31:0]                inner_in, inner_ff;
   logic signed [37:0]                s1_in, s1_ff;
   logic signed [izh_pkg::DATA_W-1:0] a2_ff;
   logic signed [izh_pkg::SYN_W-1:0]  syn2_ff;
   logic signed [56:0]                gn2_ff;

   always_comb begin
      qh_in    = 60'(sq_ff[63:24]) * 60'(izh_pkg::K_004);
      ql_full  = 44'(sq_ff[23:0]) * 44'(izh_pkg::K_004);
      ql_in    = ql_full[43:24];
      inner_in = izh_pkg::sat32(64'(bv_ff >>> 16) - 64'(side_ff[1].u));
      s1_in    = 38'(side_ff[1].v) * 38'sd5 + 38'(izh_pkg::C_140)
               - 38'(side_ff[1].u) + 38'(ext1_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         qh_ff    <= qh_in;
         ql_ff    <= ql_in;
         inner_ff <= inner_in;
         s1_ff    <= s1_in;
         a2_ff    <= a1_ff;
         syn2_ff  <= syn1_ff;
         gn2_ff   <= gn_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: quadratic term, a*(b*v - u), current sum
   // ------------------------------------------------------------------
   logic [59:0]        qsum;
   logic [43:0]        quad_in, quad_ff;
   logic signed [63:0] adu_in, adu_ff;
   logic signed [48:0] s2_in, s2_ff;

   always_comb begin
      qsum    = qh_ff + 60'(ql_ff);
      quad_in = qsum[59:16];
      adu_in  = 64'(a2_ff) * 64'(inner_ff);
      s2_in   = 49'(s1_ff) + 49'(syn2_ff >>> 1) + 49'(gn2_ff >>> 16);
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         quad_ff <= quad_in;
         adu_ff  <= adu_in;
         s2_ff   <= s2_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 4: dv and du ahead of the divide
   // ------------------------------------------------------------------
   logic signed [izh_pkg::DV_W-1:0] dv_ff, du_ff;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         dv_ff <= izh_pkg::DV_W'($signed({1'b0, quad_ff})) + izh_pkg::DV_W'(s2_ff);
         du_ff <= izh_pkg::DV_W'(adu_ff >>> 16);
      end
   end

   // ------------------------------------------------------------------
   // divide by steps_per_ms, one lane each for dv and du
   // ------------------------------------------------------------------
   logic                     qv_neg, qu_neg;
   logic [izh_pkg::MAG_W-1:0] qv_mag, qu_mag;

   izh_div #(
      .IN_W      (izh_pkg::DV_W),
      .MAG_W     (izh_pkg::MAG_W),
      .STEP_BITS (izh_pkg::DIV_STEP_BITS),
      .DIV_W     (izh_pkg::STEPS_W)
   ) u_div_v (
      .clock    (clock),
      .en       (adv[DFIRST +: DL]),
      .dividend (dv_ff),
      .divisor  (eff_div),
      .q_neg    (qv_neg),
      .q_mag    (qv_mag)
   );

   izh_div #(
      .IN_W      (izh_pkg::DV_W),
      .MAG_W     (izh_pkg::MAG_W),
      .STEP_BITS (izh_pkg::DIV_STEP_BITS),
      .DIV_W     (izh_pkg::STEPS_W)
   ) u_div_u (
      .clock    (clock),
      .en       (adv[DFIRST +: DL]),
      .dividend (du_ff),
      .divisor  (eff_div),
      .q_neg    (qu_neg),
      .q_mag    (qu_mag)
   );

   // ------------------------------------------------------------------
   // final: integrate, clamp, spike, write back
   // ------------------------------------------------------------------
   logic signed [izh_pkg::MAG_W:0]   qv_abs, qu_abs, qv, qu;
   logic signed [izh_pkg::MAG_W+1:0] vsum, usum;
   logic                             spk;

   always_comb begin
      qv_abs = $signed({1'b0, qv_mag});
      qu_abs = $signed({1'b0, qu_mag});
      qv     = qv_neg ? -qv_abs : qv_abs;
      qu     = qu_neg ? -qu_abs : qu_abs;
      vsum   = (izh_pkg::MAG_W+2)'(side_ff[LAST].v) + (izh_pkg::MAG_W+2)'(qv);
      usum   = (izh_pkg::MAG_W+2)'(side_ff[LAST].u) + (izh_pkg::MAG_W+2)'(qu);
      spk    = 1'b0;
      case (side_ff[LAST].kind)
         izh_pkg::KIND_STEP: begin
            if (vsum < (izh_pkg::MAG_W+2)'(izh_pkg::V_FLOOR)) begin
               wr_v = izh_pkg::V_FLOOR;
            end else if (vsum >= (izh_pkg::MAG_W+2)'(izh_pkg::V_PEAK)) begin
               wr_v = izh_pkg::V_PEAK;
               spk  = 1'b1;
            end else begin
               wr_v = vsum[izh_pkg::DATA_W-1:0];
            end
            wr_u = izh_pkg::sat32(64'(usum));
         end
         default: begin
            // load and spike reset carry their results from stage 1
            wr_v = side_ff[LAST].rv;
            wr_u = side_ff[LAST].ru;
         end
      endcase
   end

   // result register, parts the pipeline from the consumer
   logic [izh_pkg::NEURON_W-1:0]      out_nrn_ff;
   logic signed [izh_pkg::DATA_W-1:0] out_v_ff, out_u_ff;
   logic                              out_spk_ff;

   always_ff @(posedge clock) begin
      if (adv_out) begin
         out_nrn_ff <= side_ff[LAST].neuron;
         out_v_ff   <= wr_v;
         out_u_ff   <= wr_u;
         out_spk_ff <= spk;
      end
   end

   assign rsp_ch.valid      = out_vld_ff;
   assign rsp_ch.neuron_out = out_nrn_ff;
   assign rsp_ch.v_out      = out_v_ff;
   assign rsp_ch.u_out      = out_u_ff;
   assign rsp_ch.spiked     = out_spk_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   // a read never meets a write-back of the same neuron
   a_no_rw_clash : assert property (@(posedge clock) disable iff (reset)
      accept |-> !(ram_we && idx_ff[LAST] == req_idx))
      else $error("read and write-back of the same neuron in one cycle");

   // a taken word always occupies stage 0 next
   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      accept |=> vld_ff[0])
      else $error("accepted word lost at stage 0");

   // a spike always reports v pinned at the peak
   a_spike_peak : assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_spk_ff) |-> (out_v_ff == izh_pkg::V_PEAK))
      else $error("spike without v at peak");

endmodule

// ----- sim/tb_izhikevich_neuron_step_core.sv -----
`timescale 1ns / 1ps

module tb_izhikevich_neuron_step_core;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;
   localparam int   CYCLE_LIMIT = 400000;
   localparam int   DRAIN_CYCLES = 40;
   localparam int   HOLD_CYCLES = 400;
   localparam longint Q16 = 65536;

   // one input word as the sender builds it
   typedef struct {
      logic                              op;
      logic [izh_pkg::NEURON_W-1:0]      neuron;
      logic signed [izh_pkg::SYN_W-1:0]  syn;
      logic signed [izh_pkg::DATA_W-1:0] ext;
      logic signed [izh_pkg::DATA_W-1:0] noise;
      logic signed [izh_pkg::DATA_W-1:0] a;
      logic signed [izh_pkg::DATA_W-1:0] b;
      logic signed [izh_pkg::DATA_W-1:0] c;
      logic signed [izh_pkg::DATA_W-1:0] d;
      logic signed [izh_pkg::DATA_W-1:0] lv;
      logic signed [izh_pkg::DATA_W-1:0] lu;
   } word_type;

   typedef struct {
      logic [izh_pkg::NEURON_W-1:0]      neuron;
      logic signed [izh_pkg::DATA_W-1:0] v;
      logic signed [izh_pkg::DATA_W-1:0] u;
      logic                              spiked;
   } state_out_type;

   // what the checker waits for: the computed state and, for some table rows, a typed-in one
   typedef struct {
      state_out_type calc;
      logic          has_fixed;
      state_out_type fixed;
   } pending_type;

   logic clock;
   logic reset;
   izh_req_if req_ch ();
   izh_rsp_if rsp_ch ();
   izh_csr_if csr_ch ();

   izhikevich_neuron_step_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // own copy of the neuron memories and registers
   logic signed [izh_pkg::DATA_W-1:0] v_mem [izh_pkg::NEURONS_DEF];
   logic signed [izh_pkg::DATA_W-1:0] u_mem [izh_pkg::NEURONS_DEF];
   logic [izh_pkg::STEPS_W-1:0]       steps_cfg;
   logic [izh_pkg::GAIN_W-1:0]        gain_cfg;
   bit                                loaded [izh_pkg::NEURONS_DEF];

   pending_type   pending_q[$];
   int            errors;
   int            cycles;
   int            send_idle_pct;
   int            rsp_stall_pct;
   bit            hold_go;
   bit            hold_used;
   int            hold_left;
   bit            fixed_has;
   state_out_type fixed_word;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint clip32(input longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // one euler step of the neuron, updating the local memories
   function automatic state_out_type neuron_update(input word_type w);
      state_out_type r;
      longint v, u, vn, un, dv, du, inner, quad, dvsr;
      longint unsigned m, sq, hi, lo;
      int idx;
      idx = int'(w.neuron) % izh_pkg::NEURONS_DEF;
      v = longint'(v_mem[idx]);
      u = longint'(u_mem[idx]);
      r.spiked = 1'b0;
      if (w.op == OP_LOAD) begin
         vn = longint'(w.lv);
         un = longint'(w.lu);
      end else if (v == longint'(izh_pkg::V_PEAK)) begin
         // sitting on the peak: after-spike reset
         vn = longint'(w.c);
         un = clip32(u + longint'(w.d));
      end else begin
         m  = (v < 0) ? longint'(-v) : longint'(v);
         sq = m * m;
         hi = sq >> 24;
         lo = sq & 64'hffffff;
         quad = longint'((hi * 64'(izh_pkg::K_004) + ((lo * 64'(izh_pkg::K_004)) >> 24)) >> 16);
         dv = quad + 5 * v + longint'(izh_pkg::C_140) - u + (longint'(w.syn) >>> 1)
              + longint'(w.ext)
              + ((longint'({40'b0, gain_cfg}) * longint'(w.noise)) >>> 16);
         inner = clip32(((longint'(w.b) * v) >>> 16) - u);
         du = (longint'(w.a) * inner) >>> 16;
         dvsr = (steps_cfg == 0) ? 64'sd1 : longint'({57'b0, steps_cfg});
         vn = v + dv / dvsr;
         un = clip32(u + du / dvsr);
         if (vn < longint'(izh_pkg::V_FLOOR)) vn = longint'(izh_pkg::V_FLOOR);
         if (vn >= longint'(izh_pkg::V_PEAK)) begin
            vn = longint'(izh_pkg::V_PEAK);
            r.spiked = 1'b1;
         end
      end
      v_mem[idx] = vn[31:0];
      u_mem[idx] = un[31:0];
      r.neuron = w.neuron;
      r.v = vn[31:0];
      r.u = un[31:0];
      return r;
   endfunction

   task automatic compare_field(input string what, input longint want, input longint got);
      if (want != got) begin
         errors++;
         $display("%0t mismatch %s expected %0d actual %0d", $time, what, want, got);
      end
   endtask

   task automatic compare_word(input state_out_type want, input state_out_type got);
      compare_field("neuron_out", want.neuron, got.neuron);
      compare_field("v_out", want.v, got.v);
      compare_field("u_out", want.u, got.u);
      compare_field("spiked", want.spiked, got.spiked);
   endtask

   // sample both channels at the falling edge, where everything is settled for the next rise
   always @(negedge clock) begin
      word_type      w;
      pending_type   p;
      state_out_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            w.op = req_ch.op;                w.neuron = req_ch.neuron;
            w.syn = req_ch.syn_current;      w.ext = req_ch.ext_current;
            w.noise = req_ch.noise_sample;   w.a = req_ch.param_a;
            w.b = req_ch.param_b;            w.c = req_ch.param_c;
            w.d = req_ch.param_d;            w.lv = req_ch.load_v;
            w.lu = req_ch.load_u;
            p.calc = neuron_update(w);
            p.has_fixed = fixed_has;
            p.fixed = fixed_word;
            pending_q = {pending_q, p};
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.neuron = rsp_ch.neuron_out;
            got.v = rsp_ch.v_out;
            got.u = rsp_ch.u_out;
            got.spiked = rsp_ch.spiked;
            if (pending_q.size() == 0) begin
               errors++;
               $display("%0t unexpected word: neuron %0d v %0d u %0d spiked %0b",
                        $time, got.neuron, got.v, got.u, got.spiked);
            end else begin
               p = pending_q.pop_front();
               compare_word(p.calc, got);
               // typed-in rows are checked as well, catching a slip in either
               if (p.has_fixed) compare_word(p.fixed, got);
            end
         end
      end
   end

   // long receiver hold-off, counted here so that the sender keeps pushing meanwhile
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_used <= 1'b0;
      end else if (hold_go && !hold_used) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= (hold_left == 0) && !(hold_go && !hold_used)
                         && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic write_reg(input logic [izh_pkg::CSR_IDX_W-1:0] idx,
                            input logic [izh_pkg::CSR_DATA_W-1:0] val);
      bit taken;
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do begin
         @(negedge clock);
         taken = csr_ch.ready;
         @(posedge clock);
      end while (!taken);
      if (idx == izh_pkg::REG_STEPS) steps_cfg = val[izh_pkg::STEPS_W-1:0];
      else gain_cfg = val;
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // offer one word, wait until taken, then maybe leave a gap
   task automatic send_word(input word_type w, input bit has_fixed, input state_out_type fx);
      bit taken;
      req_ch.valid <= 1'b1;
      req_ch.op <= w.op;                req_ch.neuron <= w.neuron;
      req_ch.syn_current <= w.syn;      req_ch.ext_current <= w.ext;
      req_ch.noise_sample <= w.noise;   req_ch.param_a <= w.a;
      req_ch.param_b <= w.b;            req_ch.param_c <= w.c;
      req_ch.param_d <= w.d;            req_ch.load_v <= w.lv;
      req_ch.load_u <= w.lu;
      fixed_has <= has_fixed;
      fixed_word <= fx;
      do begin
         @(negedge clock);
         taken = req_ch.ready;
         @(posedge clock);
      end while (!taken);
      if (w.op == OP_LOAD) loaded[int'(w.neuron) % izh_pkg::NEURONS_DEF] = 1'b1;
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rnd_around(input int centre, input int spread);
      return 32'(centre + $signed($urandom_range(2 * spread)) - spread);
   endfunction

   // random word: a load first for each neuron, then mostly plausible steps, some wild values
   function automatic word_type random_word();
      word_type w;
      bit       wild;
      w.neuron = ($urandom_range(1)) ? 10'($urandom_range(15)) : 10'($urandom_range(1023));
      if ($urandom_range(9) == 0) w.neuron = 10'(1023 - $urandom_range(3));
      w.op = (!loaded[w.neuron] || $urandom_range(7) == 0) ? OP_LOAD : OP_STEP;
      wild = ($urandom_range(6) == 0);
      w.syn = 48'({$urandom, $urandom});
      w.ext = $urandom;   w.noise = $urandom;
      w.a = $urandom;     w.b = $urandom;
      w.c = $urandom;     w.d = $urandom;
      w.lv = $urandom;    w.lu = $urandom;
      if (!wild) begin
         w.syn   = 48'(rnd_around(0, 20 << 17));
         w.ext   = rnd_around(5 << 16, 15 << 16);
         w.noise = rnd_around(0, 3 << 16);
         w.a     = rnd_around(1311, 1200);
         w.b     = rnd_around(13107, 6000);
         w.c     = rnd_around(-65 << 16, 10 << 16);
         w.d     = rnd_around(6 << 16, 4 << 16);
         w.lv    = ($urandom_range(5) == 0) ? izh_pkg::V_PEAK : rnd_around(-40 << 16, 60 << 16);
         w.lu    = rnd_around(-10 << 16, 10 << 16);
      end
      return w;
   endfunction

   function automatic word_type blank_word(input logic op, input int n);
      word_type w;
      w.op = op; w.neuron = 10'(n);
      w.syn = '0; w.ext = '0; w.noise = '0; w.a = '0; w.b = '0; w.c = '0; w.d = '0;
      w.lv = '0; w.lu = '0;
      return w;
   endfunction

   function automatic state_out_type typed(input int n, input longint v, input longint u,
                                           input bit s);
      state_out_type r;
      r.neuron = 10'(n); r.v = v[31:0]; r.u = u[31:0]; r.spiked = s;
      return r;
   endfunction

   word_type      dir_words [$];
   bit            dir_has [$];
   state_out_type dir_fixed [$];

   task automatic add_row(input word_type w, input bit has, input state_out_type fx);
      dir_words = {dir_words, w};
      dir_has   = {dir_has, has};
      dir_fixed = {dir_fixed, fx};
   endtask

   task automatic run_random(input int count);
      state_out_type none;
      none = typed(0, 0, 0, 0);
      repeat (count) send_word(random_word(), 1'b0, none);
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      word_type      w;
      state_out_type none;
      int            phase_steps [6];
      int            phase_gain  [6];
      int            phase_idle  [6];
      int            phase_stall [6];

      phase_steps = '{1, 64, 4, 0, 127, 2};
      phase_gain  = '{0, 24'hffffff, 24'h010000, 24'h000800, 0, 24'h123456};
      phase_idle  = '{0, 84, 0, 30, 0, 0};
      phase_stall = '{0, 0, 84, 30, 0, 10};
      errors = 0;
      cycles = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_go = 1'b0;
      fixed_has = 1'b0;
      steps_cfg = 1;
      gain_cfg = 0;
      none = typed(0, 0, 0, 0);
      fixed_word = none;
      for (int i = 0; i < izh_pkg::NEURONS_DEF; i++) begin
         v_mem[i] = '0; u_mem[i] = '0; loaded[i] = 1'b0;
      end
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.op <= OP_LOAD;      req_ch.neuron <= '0;
      req_ch.syn_current <= '0;  req_ch.ext_current <= '0;
      req_ch.noise_sample <= '0; req_ch.param_a <= '0;
      req_ch.param_b <= '0;      req_ch.param_c <= '0;
      req_ch.param_d <= '0;      req_ch.load_v <= '0;
      req_ch.load_u <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= izh_pkg::REG_STEPS;
      csr_ch.data  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, registers at reset values
      w = blank_word(OP_LOAD, 0);
      add_row(w, 1, typed(0, 0, 0, 0));
      w = blank_word(OP_LOAD, 1023); w.lv = 32'sh7fffffff; w.lu = 32'sh80000000;
      add_row(w, 1, typed(1023, 32'sh7fffffff, -64'sd2147483648, 0));
      w = blank_word(OP_STEP, 0);                      // resting neuron, zero inputs
      add_row(w, 0, none);
      w = blank_word(OP_STEP, 1023);                   // extreme state, extreme params
      w.syn = 48'sh7fffffffffff; w.ext = 32'sh7fffffff; w.noise = 32'sh80000000;
      w.a = 32'sh7fffffff; w.b = 32'sh80000000;
      add_row(w, 0, none);
      w = blank_word(OP_LOAD, 5); w.lv = izh_pkg::V_PEAK; w.lu = 32'sh7fff0000;
      add_row(w, 1, typed(5, izh_pkg::V_PEAK, 32'sh7fff0000, 0));
      // reset step on the peak, u + d saturating high
      w = blank_word(OP_STEP, 5); w.c = 32'(-65 * Q16); w.d = 32'sh7fffffff;
      add_row(w, 1, typed(5, -65 * Q16, 32'sh7fffffff, 0));
      w = blank_word(OP_LOAD, 6); w.lv = izh_pkg::V_PEAK; w.lu = 32'sh80000000;
      add_row(w, 0, none);
      // reset step with u + d saturating low
      w = blank_word(OP_STEP, 6); w.c = 32'sh80000000; w.d = 32'sh80000000;
      add_row(w, 1, typed(6, -64'sd2147483648, -64'sd2147483648, 0));
      w = blank_word(OP_LOAD, 7); w.lv = 32'(29 * Q16);
      add_row(w, 0, none);
      // strong drive crosses the threshold: pinned at the peak with a spike
      w = blank_word(OP_STEP, 7); w.ext = 32'sh7fffffff;
      add_row(w, 1, typed(7, izh_pkg::V_PEAK, 0, 1));
      w = blank_word(OP_LOAD, 8); w.lv = 32'(-99 * Q16);
      add_row(w, 0, none);
      // strong negative drive hits the floor
      w = blank_word(OP_STEP, 8); w.ext = 32'sh80000000;
      add_row(w, 1, typed(8, izh_pkg::V_FLOOR, 0, 0));
      w = blank_word(OP_STEP, 8); w.syn = 48'sh800000000000; w.a = 32'sh80000000;
      w.b = 32'sh7fffffff;
      add_row(w, 0, none);
      w = blank_word(OP_LOAD, 9); w.lv = 32'sh80000000; w.lu = 32'sh7fffffff;
      add_row(w, 0, none);
      w = blank_word(OP_STEP, 9); w.a = 32'sh00000520; w.b = 32'sh00003333;
      w.syn = 48'sh000000123457; w.ext = 32'(10 * Q16);
      add_row(w, 0, none);
      w = blank_word(OP_STEP, 7); w.c = 32'(-50 * Q16); w.d = 32'(2 * Q16);  // reset after the spike
      add_row(w, 0, none);
      foreach (dir_words[i]) send_word(dir_words[i], dir_has[i], dir_fixed[i]);
      req_ch.valid <= 1'b0;
      fixed_has <= 1'b0;
      @(posedge clock);

      // random phases, each with its own register setting and idling
      for (int ph = 0; ph < 6; ph++) begin
         wait_drained();
         write_reg(izh_pkg::REG_STEPS, izh_pkg::CSR_DATA_W'(phase_steps[ph]));
         write_reg(izh_pkg::REG_GAIN, izh_pkg::CSR_DATA_W'(phase_gain[ph]));
         send_idle_pct = phase_idle[ph];
         rsp_stall_pct = phase_stall[ph];
         if (ph == 4) hold_go = 1'b1;          // receiver holds off, input backs up
         if (ph == 5) begin
            // last phase switches idling on the fly for mixed stretches
            run_random(90);
            send_idle_pct = 84; rsp_stall_pct = 84;
            run_random(90);
            send_idle_pct = 0;  rsp_stall_pct = 0;
            run_random(80);
         end else begin
            run_random(265);
         end
      end

      wait_drained();
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/izh_pkg.sv
hdl/izh_if.sv
hdl/izh_ram.sv
hdl/izh_div.sv
hdl/izhikevich_neuron_step_core.sv
sim/tb_izhikevich_neuron_step_core.sv
